// ===== hw/rtl/ell_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ell_pkg
// Types and codes shared by the line lexer and its transition logic.
// ----------------------------------------------------------------------------
package ell_pkg;

    typedef enum logic [2:0] {
        ST_BEFORE_NAME,
        ST_IN_NAME,
        ST_BEFORE_VALUE,
        ST_QUOTED,
        ST_UNQUOTED,
        ST_BETWEEN,
        ST_AFTER
    } t_lex_st;

    typedef enum logic [2:0] {
        KIND_NAME    = 3'd0,
        KIND_VALUE   = 3'd1,
        KIND_END     = 3'd2,
        KIND_INVALID = 3'd3,
        KIND_QUOTE   = 3'd4,
        KIND_LONG    = 3'd5
    } t_kind;

    typedef struct packed {
        t_lex_st    st;
        logic       esc;
        logic [7:0] open_quote;
        logic       name_seen;
        logic       rest_ignored;
    } t_line_state;

    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam t_line_state LINE_IDLE = '{
        st:           ST_BEFORE_NAME,
        esc:          1'b0,
        open_quote:   CH_SPACE,
        name_seen:    1'b0,
        rest_ignored: 1'b0
    };

    typedef struct packed {
        logic       emit;
        t_kind      kind;
        logic [7:0] data;
        logic       halt;
        logic       line_end;
        logic       col_inc;
    } t_step_res;

endpackage
`default_nettype wire

// ===== hw/rtl/ell_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ell_step
// One-byte transition of the line lexer: next line state and the result.
// ----------------------------------------------------------------------------
module ell_step (
    input  var ell_pkg::t_line_state i_cur,
    input  var logic [7:0]           i_ch,
    input  var logic                 i_col_full,
    output ell_pkg::t_line_state     o_nxt,
    output ell_pkg::t_step_res       o_res
);

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_BQ    = 8'h60;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    logic is_alpha;
    logic is_digit;
    logic is_blank;
    logic is_quote;

    assign is_alpha = i_ch inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    assign is_digit = i_ch inside {[8'h30:8'h39]};
    assign is_blank = i_ch inside {ell_pkg::CH_SPACE, CH_TAB};
    assign is_quote = i_ch inside {CH_SQ, CH_DQ, CH_BQ};

    always_comb begin
        o_nxt          = i_cur;
        o_res.emit     = 1'b0;
        o_res.kind     = ell_pkg::KIND_VALUE;
        o_res.data     = i_ch;
        o_res.halt     = 1'b0;
        o_res.line_end = 1'b0;
        o_res.col_inc  = 1'b0;
        if (i_ch == CH_LF) begin
            if (i_cur.st == ell_pkg::ST_QUOTED) begin
                o_res.emit = 1'b1;
                o_res.kind = ell_pkg::KIND_QUOTE;
                o_res.data = i_cur.open_quote;
                o_res.halt = 1'b1;
            end else begin
                o_res.emit     = i_cur.name_seen;
                o_res.kind     = ell_pkg::KIND_END;
                o_res.data     = 8'h00;
                o_res.line_end = 1'b1;
                o_nxt          = ell_pkg::LINE_IDLE;
            end
        end else if (i_col_full) begin
            o_res.emit = 1'b1;
            o_res.kind = ell_pkg::KIND_LONG;
            o_res.data = 8'h00;
            o_res.halt = 1'b1;
        end else begin
            o_res.col_inc = 1'b1;
            if (i_cur.rest_ignored || i_cur.st == ell_pkg::ST_AFTER) begin
                o_res.emit = 1'b0;
            end else if (i_ch == CH_NUL) begin
                o_nxt.rest_ignored = 1'b1;
            end else begin
                case (i_cur.st)
                    ell_pkg::ST_BEFORE_NAME, ell_pkg::ST_IN_NAME: begin
                        if (is_alpha || i_ch == CH_UNDER ||
                            (i_cur.st == ell_pkg::ST_IN_NAME && is_digit)) begin
                            o_nxt.st        = ell_pkg::ST_IN_NAME;
                            o_nxt.name_seen = 1'b1;
                            o_res.emit      = 1'b1;
                            o_res.kind      = ell_pkg::KIND_NAME;
                        end else if (is_blank) begin
                            if (i_cur.st == ell_pkg::ST_IN_NAME) begin
                                o_nxt.st = ell_pkg::ST_BEFORE_VALUE;
                            end
                        end else if (i_ch == CH_HASH) begin
                            o_nxt.st = ell_pkg::ST_AFTER;
                        end else begin
                            o_res.emit = 1'b1;
                            o_res.kind = ell_pkg::KIND_INVALID;
                            o_res.halt = 1'b1;
                        end
                    end
                    ell_pkg::ST_BEFORE_VALUE, ell_pkg::ST_BETWEEN: begin
                        if (is_quote) begin
                            o_nxt.st         = ell_pkg::ST_QUOTED;
                            o_nxt.open_quote = i_ch;
                            o_res.emit       = 1'b1;
                        end else if (i_ch == CH_BSL) begin
                            o_nxt.st   = ell_pkg::ST_UNQUOTED;
                            o_nxt.esc  = 1'b1;
                            o_res.emit = 1'b1;
                        end else if (is_blank) begin
                            if (i_cur.st == ell_pkg::ST_BETWEEN) begin
                                o_nxt.st = ell_pkg::ST_AFTER;
                            end
                        end else if (i_ch == CH_HASH) begin
                            o_nxt.st = ell_pkg::ST_AFTER;
                        end else begin
                            o_nxt.st   = ell_pkg::ST_UNQUOTED;
                            o_res.emit = 1'b1;
                        end
                    end
                    ell_pkg::ST_QUOTED: begin
                        o_res.emit = 1'b1;
                        if (i_cur.esc) begin
                            o_nxt.esc = 1'b0;
                        end else if (i_ch == i_cur.open_quote) begin
                            o_nxt.st = ell_pkg::ST_BETWEEN;
                        end else if (i_ch == CH_BSL) begin
                            o_nxt.esc = 1'b1;
                        end
                    end
                    ell_pkg::ST_UNQUOTED: begin
                        o_res.emit = 1'b1;
                        if (i_cur.esc) begin
                            o_nxt.esc = 1'b0;
                        end else if (i_ch == CH_BSL) begin
                            o_nxt.esc = 1'b1;
                        end else if (is_quote) begin
                            o_nxt.st         = ell_pkg::ST_QUOTED;
                            o_nxt.open_quote = i_ch;
                        end else if (is_blank || i_ch == CH_HASH) begin
                            o_nxt.st   = ell_pkg::ST_AFTER;
                            o_res.emit = 1'b0;
                        end
                    end
                    default: begin
                        o_nxt.st = ell_pkg::ST_AFTER;
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/env_line_lexer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Result: on the master side in the cycle after its byte's transfer.
// Throughput: one byte per cycle unless stalled; state updates until halt.
// Output register: a new byte is taken while the result waits, if it is taken.
// Reset: synchronous, active low; clears lexer and output state; line count to 1.
// ----------------------------------------------------------------------------
// env_line_lexer_top
// Byte stream lexer for NAME VALUE lines, emitting tagged name/value/status bytes.
// ----------------------------------------------------------------------------
module env_line_lexer_top #(
    parameter int LINE_MAX         = 1022,
    parameter int LINE_NUMBER_BITS = 16
) (
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    input  var logic        i_s_tvalid,
    output logic            o_s_tready,
    input  var logic [7:0]  i_s_tdata,   // [7:0] ch
    output logic            o_m_tvalid,
    input  var logic        i_m_tready,
    output logic [23:0]     o_m_tdata,   // [7:0] data_byte, [23:8] line_number
    output logic [2:0]      o_m_tuser    // [2:0] kind
);

    localparam int COL_W = $clog2(LINE_MAX);
    localparam int LN_W  = LINE_NUMBER_BITS;

    ell_pkg::t_line_state r_line;
    ell_pkg::t_line_state n_line;
    ell_pkg::t_step_res   step_res;
    logic [COL_W-1:0]     r_col;
    logic [LN_W-1:0]      r_line_count;
    logic                 r_halted;
    logic                 r_m_valid;
    logic [2:0]           r_kind;
    logic [7:0]           r_data;
    logic [15:0]          r_line_num;
    logic                 s_xfer;
    logic                 col_full;
    logic                 live;

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign col_full   = r_col >= COL_W'(LINE_MAX - 1);
    assign live       = s_xfer && !r_halted;

    ell_step u_step (
        .i_cur      (r_line),
        .i_ch       (i_s_tdata),
        .i_col_full (col_full),
        .o_nxt      (n_line),
        .o_res      (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line       <= ell_pkg::LINE_IDLE;
            r_col        <= '0;
            r_line_count <= LN_W'(1);
            r_halted     <= 1'b0;
        end else if (live) begin
            r_line <= n_line;
            if (step_res.halt) begin
                r_halted <= 1'b1;
            end
            if (step_res.line_end) begin
                r_col <= '0;
                if (r_line_count != '1) begin
                    r_line_count <= r_line_count + LN_W'(1);
                end
            end else if (step_res.col_inc) begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (live && step_res.emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (live && step_res.emit) begin
            r_kind     <= step_res.kind;
            r_data     <= step_res.data;
            r_line_num <= 16'(r_line_count);
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {r_line_num, r_data};
    assign o_m_tuser  = r_kind;

endmodule
`default_nettype wire
